### design/isp_pkg.sv
// shared types and constants of the imu shake and pickup detector
// no dependencies; imported by every module of the block
`default_nettype none

package isp_pkg;

    localparam int AXIS_W    = 16;   // raw sensor sample
    localparam int MAG_W     = 16;   // vector magnitude
    localparam int SQ_W      = 32;   // sum of three squares
    localparam int CFG_W     = 16;   // configuration register
    localparam int CFG_IDX_W = 2;
    localparam int SQ_CNT_W  = 3;
    localparam int ROOT_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAKE_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_LEVEL    = 2'd2;

    localparam logic [CFG_W-1:0] SHAKE_THRESHOLD_RST  = 16'd13100;
    localparam logic [CFG_W-1:0] PICKUP_THRESHOLD_RST = 16'd1024;
    localparam logic [CFG_W-1:0] GRAVITY_LEVEL_RST    = 16'd4096;

    // square phase: six products, last accumulate in the cycle after the last product
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = 3'd6;
    localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = 4'd15;

    // largest floor root of three full-scale squares
    localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_A_START,
        ST_ROOT_A_WAIT,
        ST_ROOT_G_START,
        ST_ROOT_G_WAIT,
        ST_UPDATE,
        ST_FLAGS
    } isp_state_t;

    typedef struct packed {
        logic rd_en;    // fetch the entry about to be replaced
        logic update;   // write new magnitudes, adjust the sums
    } isp_win_cmd_t;

endpackage

`default_nettype wire

### design/isp_sqrt.sv
// iterative floor square root, one result bit per cycle
// depends on isp_pkg
`default_nettype none

module isp_sqrt
    import isp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   done,
    output logic [MAG_W-1:0]       root
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]       rad_reg, rad_next;
    logic [MAG_W+1:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]      root_reg, root_next;

    logic [MAG_W+3:0] cur;
    logic [MAG_W+3:0] trial;

    assign cur   = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (cur >= trial)
            begin
                rem_next  = (MAG_W+2)'(cur - trial);
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (MAG_W+2)'(cur);
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ROOT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### design/isp_window.sv
// circular magnitude window in a memory with running sums
// depends on isp_pkg
`default_nettype none

module isp_window
    import isp_pkg::*;
#(
    parameter int WINDOW = 16,
    parameter int SUMW   = 20
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire isp_win_cmd_t       cmd,
    input  wire logic [MAG_W-1:0]   accel_mag,
    input  wire logic [MAG_W-1:0]   gyro_mag,
    output logic [SUMW-1:0]         accel_sum,
    output logic [SUMW-1:0]         gyro_sum
);

    localparam int SLOTW = $clog2(WINDOW);
    localparam logic [SLOTW-1:0] SLOT_LAST = SLOTW'(WINDOW - 1);

    // accel magnitude in the upper half, gyro in the lower
    logic [2*MAG_W-1:0] win_ram [WINDOW];
    logic [2*MAG_W-1:0] rd_data_reg;

    logic [SLOTW-1:0] slot_reg, slot_next;
    logic             full_reg, full_next;
    logic [SUMW-1:0]  accel_sum_reg, accel_sum_next;
    logic [SUMW-1:0]  gyro_sum_reg, gyro_sum_next;
    logic [MAG_W-1:0] old_accel, old_gyro;

    // entries not yet written in the first pass count as zero
    assign old_accel = full_reg ? rd_data_reg[2*MAG_W-1:MAG_W] : '0;
    assign old_gyro  = full_reg ? rd_data_reg[MAG_W-1:0] : '0;

    always_comb
    begin
        slot_next      = slot_reg;
        full_next      = full_reg;
        accel_sum_next = accel_sum_reg;
        gyro_sum_next  = gyro_sum_reg;
        if (cmd.update)
        begin
            accel_sum_next = accel_sum_reg - SUMW'(old_accel) + SUMW'(accel_mag);
            gyro_sum_next  = gyro_sum_reg - SUMW'(old_gyro) + SUMW'(gyro_mag);
            if (slot_reg == SLOT_LAST)
            begin
                slot_next = '0;
                full_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            accel_sum_reg <= '0;
            gyro_sum_reg  <= '0;
        end
        else
        begin
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            accel_sum_reg <= accel_sum_next;
            gyro_sum_reg  <= gyro_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= win_ram[slot_reg];
        end
        if (cmd.update)
        begin
            win_ram[slot_reg] <= {accel_mag, gyro_mag};
        end
    end

    assign accel_sum = accel_sum_reg;
    assign gyro_sum  = gyro_sum_reg;

endmodule

`default_nettype wire

### design/imu_shake_pickup_detector.sv
// imu shake and pickup detector, top level: sequencer, shared squarer, flags
// depends on isp_pkg, isp_sqrt and isp_window
`default_nettype none

// One word is taken, then in_stall stays high for the whole computation; a
// new word is taken only once the last one is finished. The time per word
// goes to the single 16x16 squarer (six axes plus one accumulate) and above
// all to the one square root unit, which yields one result bit per cycle
// and runs twice per word (accel, then gyro, each after a start state),
// followed by a window update state and a flag evaluation state. The
// finished result sits in an output register, so the next word is accepted
// while it still waits for the consumer; only when a second result is ready
// before the first is taken does the block hold. The window (WINDOW entries
// per sensor) lives in a memory; its contents are treated as zero until the
// first full pass is written, so no clearing pass is needed after reset.
// Configuration writes land at once, at any time.
module imu_shake_pickup_detector
    import isp_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    // input word
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [AXIS_W-1:0]     accel_x,
    input  wire logic [AXIS_W-1:0]     accel_y,
    input  wire logic [AXIS_W-1:0]     accel_z,
    input  wire logic [AXIS_W-1:0]     gyro_x,
    input  wire logic [AXIS_W-1:0]     gyro_y,
    input  wire logic [AXIS_W-1:0]     gyro_z,
    // result word
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [MAG_W-1:0]           accel_magnitude,
    output logic [MAG_W-1:0]           gyro_magnitude,
    output logic                       shaken,
    output logic                       picked_up
);

    // window sums and scaled thresholds share this width
    localparam int SUMW = MAG_W + $clog2(WINDOW);
    localparam logic [SUMW-1:0] WIN_K = SUMW'(WINDOW);

    isp_state_t state_reg, state_next;

    // configuration registers
    logic [CFG_W-1:0] shake_th_reg, shake_th_next;
    logic [CFG_W-1:0] pickup_th_reg, pickup_th_next;
    logic [CFG_W-1:0] gravity_reg, gravity_next;

    // captured sample
    logic signed [AXIS_W-1:0] axis_reg [6];

    // squarer and accumulators
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;
    logic signed [AXIS_W-1:0] sq_operand;
    logic signed [2*AXIS_W-1:0] sq_product;
    logic [SQ_W-1:0] prod_reg;
    logic [SQ_W-1:0] acc_a_reg, acc_g_reg;

    // root results
    logic [MAG_W-1:0] accel_mag_reg, gyro_mag_reg;

    // scaled thresholds
    logic [SUMW-1:0] shake_scaled_reg, pickup_scaled_reg, grav_scaled_reg;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [MAG_W-1:0] out_accel_reg, out_gyro_reg;
    logic             out_shaken_reg, out_picked_reg;

    // sequencer outputs
    logic          in_take;
    logic          out_free;
    logic          load_out;
    logic [SQ_W-1:0] root_radicand;
    logic          root_start;
    logic          root_done;
    logic [MAG_W-1:0] root_value;
    isp_win_cmd_t  win_cmd;

    logic [SUMW-1:0] accel_sum, gyro_sum;
    logic [SUMW-1:0] deviation;
    logic            flag_shaken, flag_picked;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_cnt_reg == SQ_LAST)
                begin
                    state_next = ST_ROOT_A_START;
                end
            end
            ST_ROOT_A_START: state_next = ST_ROOT_A_WAIT;
            ST_ROOT_A_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ST_ROOT_G_START;
                end
            end
            ST_ROOT_G_START: state_next = ST_ROOT_G_WAIT;
            ST_ROOT_G_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_FLAGS;
            ST_FLAGS:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        root_start     = 1'b0;
        root_radicand  = acc_a_reg;
        win_cmd        = '0;
        load_out       = 1'b0;
        sq_cnt_next    = sq_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sq_cnt_next = '0;
            end
            ST_SQUARE:
            begin
                sq_cnt_next = sq_cnt_reg + 1'b1;
                // old window entry is fetched while the squares run
                win_cmd.rd_en = (sq_cnt_reg == '0);
            end
            ST_ROOT_A_START:
            begin
                root_start     = 1'b1;
                root_radicand  = acc_a_reg;
            end
            ST_ROOT_G_START:
            begin
                root_start     = 1'b1;
                root_radicand  = acc_g_reg;
            end
            ST_UPDATE:
            begin
                win_cmd.update = 1'b1;
            end
            ST_FLAGS:
            begin
                load_out = out_free;
            end
            default:
            begin
                sq_cnt_next = sq_cnt_reg;
            end
        endcase
    end

    // ---------------- shared squarer ----------------
    always_comb
    begin
        case (sq_cnt_reg)
            3'd0:    sq_operand = axis_reg[0];
            3'd1:    sq_operand = axis_reg[1];
            3'd2:    sq_operand = axis_reg[2];
            3'd3:    sq_operand = axis_reg[3];
            3'd4:    sq_operand = axis_reg[4];
            3'd5:    sq_operand = axis_reg[5];
            default: sq_operand = '0;
        endcase
    end

    assign sq_product = sq_operand * sq_operand;

    // ---------------- shared root unit ----------------
    isp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (root_radicand),
        .done     (root_done),
        .root     (root_value)
    );

    // ---------------- magnitude window ----------------
    isp_window #(
        .WINDOW (WINDOW),
        .SUMW   (SUMW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (win_cmd),
        .accel_mag (accel_mag_reg),
        .gyro_mag  (gyro_mag_reg),
        .accel_sum (accel_sum),
        .gyro_sum  (gyro_sum)
    );

    // ---------------- flags, exact on the scaled sums ----------------
    assign deviation = (accel_sum >= grav_scaled_reg) ? (accel_sum - grav_scaled_reg)
                                                      : (grav_scaled_reg - accel_sum);
    assign flag_shaken = (gyro_sum > shake_scaled_reg);
    // calm rotation: twice the gyro sum stays under the scaled shake threshold
    assign flag_picked = (deviation > pickup_scaled_reg)
                      && ({gyro_sum, 1'b0} < {1'b0, shake_scaled_reg});

    // ---------------- configuration ----------------
    always_comb
    begin
        shake_th_next  = shake_th_reg;
        pickup_th_next = pickup_th_reg;
        gravity_next   = gravity_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SHAKE_THRESHOLD:  shake_th_next  = cfg_data;
                CFG_PICKUP_THRESHOLD: pickup_th_next = cfg_data;
                CFG_GRAVITY_LEVEL:    gravity_next   = cfg_data;
                default:              shake_th_next  = shake_th_reg;
            endcase
        end
    end

    // result held until taken, refilled when the consumer frees it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            shake_th_reg  <= SHAKE_THRESHOLD_RST;
            pickup_th_reg <= PICKUP_THRESHOLD_RST;
            gravity_reg   <= GRAVITY_LEVEL_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sq_cnt_reg    <= sq_cnt_next;
            out_valid_reg <= out_valid_next;
            shake_th_reg  <= shake_th_next;
            pickup_th_reg <= pickup_th_next;
            gravity_reg   <= gravity_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            axis_reg[0] <= accel_x;
            axis_reg[1] <= accel_y;
            axis_reg[2] <= accel_z;
            axis_reg[3] <= gyro_x;
            axis_reg[4] <= gyro_y;
            axis_reg[5] <= gyro_z;
        end

        if (state_reg == ST_SQUARE)
        begin
            prod_reg <= SQ_W'(sq_product);
            // product of the previous cycle goes into its sensor's sum
            case (sq_cnt_reg) inside
                3'd0:
                begin
                    acc_a_reg <= '0;
                    acc_g_reg <= '0;
                end
                3'd1, 3'd2, 3'd3: acc_a_reg <= acc_a_reg + prod_reg;
                3'd4, 3'd5, 3'd6: acc_g_reg <= acc_g_reg + prod_reg;
                default:          acc_g_reg <= acc_g_reg;
            endcase
        end

        if (state_reg == ST_ROOT_A_WAIT && root_done)
        begin
            accel_mag_reg <= root_value;
        end
        if (state_reg == ST_ROOT_G_WAIT && root_done)
        begin
            gyro_mag_reg <= root_value;
        end

        if (state_reg == ST_UPDATE)
        begin
            shake_scaled_reg  <= {{(SUMW-CFG_W){1'b0}}, shake_th_reg} * WIN_K;
            pickup_scaled_reg <= {{(SUMW-CFG_W){1'b0}}, pickup_th_reg} * WIN_K;
            grav_scaled_reg   <= {{(SUMW-CFG_W){1'b0}}, gravity_reg} * WIN_K;
        end

        if (load_out)
        begin
            out_accel_reg  <= accel_mag_reg;
            out_gyro_reg   <= gyro_mag_reg;
            out_shaken_reg <= flag_shaken;
            out_picked_reg <= flag_picked;
        end
    end

    assign out_valid       = out_valid_reg;
    assign accel_magnitude = out_accel_reg;
    assign gyro_magnitude  = out_gyro_reg;
    assign shaken          = out_shaken_reg;
    assign picked_up       = out_picked_reg;

`ifndef SYNTHESIS
    // the root unit reports only while the sequencer waits for it
    a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == ST_ROOT_A_WAIT || state_reg == ST_ROOT_G_WAIT))
        else $error("root unit finished outside a wait state");

    // one word at a time: a taken word closes the input side next cycle
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input side open right after taking a word");

    // magnitudes never exceed the full-scale root
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accel_magnitude <= MAG_MAX && gyro_magnitude <= MAG_MAX))
        else $error("magnitude above full-scale root");
`endif

endmodule

`default_nettype wire
